// File: hw/rtl/image_map_hit_test_defines.svh
// Assertion macros shared by the image-map hit test RTL.
`ifndef IMAGE_MAP_HIT_TEST_DEFINES_SVH
`define IMAGE_MAP_HIT_TEST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IMHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/imht_pkg.sv
// Types, codes and helper functions for the image-map hit test.
package imht_pkg;

  localparam int COORD_W = 16;
  localparam int PT_W    = 15;
  localparam int DIFF_W  = 17;
  localparam int PROD_W  = 34;
  localparam int ACC_W   = 36;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_APPEND = 2'd2;
  localparam logic [1:0] ACT_QUERY  = 2'd3;

  localparam logic [2:0] SH_RECT    = 3'd0;
  localparam logic [2:0] SH_CIRCLE  = 3'd1;
  localparam logic [2:0] SH_POLY    = 3'd2;
  localparam logic [2:0] SH_DEFAULT = 3'd3;
  localparam logic [2:0] SH_UNKNOWN = 3'd4;

  localparam logic [1:0] MK_INSIDE  = 2'd0;
  localparam logic [1:0] MK_DEFAULT = 2'd1;
  localparam logic [1:0] MK_NEAREST = 2'd2;
  localparam logic [1:0] MK_NONE    = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_APPEND, ST_QRD, ST_QREC, ST_GA, ST_GB, ST_RECT,
    ST_CDX, ST_CDY, ST_CR, ST_CCMP,
    ST_PXA, ST_PXB, ST_PYA, ST_PYB, ST_PVTX, ST_E1, ST_E2, ST_E3,
    ST_NEXT, ST_NRD, ST_NREC, ST_DIV, ST_NDX, ST_NDY, ST_NCMP, ST_DONE
  } imht_state_t;

  function automatic logic signed [DIFF_W-1:0] sx17(input logic signed [COORD_W-1:0] v);
    sx17 = {v[COORD_W-1], v};
  endfunction

  function automatic logic signed [DIFF_W-1:0] pt17(input logic [PT_W-1:0] v);
    pt17 = {2'b00, v};
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_prod(input logic signed [PROD_W-1:0] v);
    ext_prod = {{(ACC_W-PROD_W){v[PROD_W-1]}}, v};
  endfunction

endpackage

// File: hw/rtl/image_map_hit_test.sv
// Image-map area table with point hit test, nearest-centre fallback and APB registers.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_stall    action, shape, coordinate, point
//   out_     output     out_valid/out_stall  match kind, area index, overflow
//   apb      input      psel/penable/pready  char_width_px, line_height_px
//
// Clear and start complete in the idle state; an append reads the area record, then writes
// it back. A query reads each area record and fetches its coordinates, works each polygon
// edge on the shared multiplier, and a nearest pass runs the restoring divider on the x and
// y sums of each rect or poly area.
// Reset is synchronous and clears the control state; the memories hold no reset value.
// A finished result waits in the output register while new words are accepted.
`include "image_map_hit_test_defines.svh"

module image_map_hit_test
  import imht_pkg::*;
#(
  parameter int MAX_AREAS  = 16,
  parameter int MAX_COORDS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_action,
  input  logic [2:0]                in_area_shape,
  input  logic signed [COORD_W-1:0] in_coord_value,
  input  logic [PT_W-1:0]           in_point_x,
  input  logic [PT_W-1:0]           in_point_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_match_kind,
  output logic [3:0]                out_area_index,
  output logic                      out_table_overflow,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int AW  = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
  localparam int UW  = $clog2(MAX_AREAS + 1);
  localparam int KW  = $clog2(MAX_COORDS);
  localparam int CW  = $clog2(MAX_COORDS + 1);
  localparam int PW  = CW - 1;
  localparam int SW  = COORD_W + 1 + KW;
  localparam int DCW = $clog2(SW + 1);

  typedef struct packed {
    logic [2:0]           shape;
    logic [CW-1:0]        count;
    logic signed [SW-1:0] sumx;
    logic signed [SW-1:0] sumy;
  } area_rec_t;

  // Memories
  area_rec_t                 area_mem  [2**AW];
  logic signed [COORD_W-1:0] coord_mem [2**(AW+KW)];
  area_rec_t                 rec_q;
  logic signed [COORD_W-1:0] cq;
  logic [AW-1:0]             area_raddr, area_waddr;
  logic                      area_we;
  area_rec_t                 area_wdata;
  logic                      coord_we;
  logic [AW+KW-1:0]          coord_waddr;

  // Control and datapath registers
  imht_state_t               state_r, state_nxt;
  logic [UW-1:0]             used_r, used_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      open_r, open_nxt;
  logic signed [COORD_W-1:0] lastx_r, lastx_nxt;
  logic signed [COORD_W-1:0] cin_r, cin_nxt;
  logic [PT_W-1:0]           px_r, px_nxt, py_r, py_nxt;
  logic [UW-1:0]             i_r, i_nxt;
  logic [CW-1:0]             k_r, k_nxt;
  logic signed [DIFF_W-1:0]  g_r [4];
  logic signed [DIFF_W-1:0]  g_nxt [4];
  logic signed [COORD_W-1:0] ax_r, ax_nxt, ay_r, ay_nxt, bx_r, bx_nxt, by_r, by_nxt;
  logic signed [COORD_W-1:0] fx_r, fx_nxt, fy_r, fy_nxt;
  logic                      closed_r, closed_nxt;
  logic signed [CW:0]        wind_r, wind_nxt;
  logic                      hdef_r, hdef_nxt;
  logic [UW-1:0]             didx_r, didx_nxt;
  logic [1:0]                kind_r, kind_nxt;
  logic [UW-1:0]             idx_r, idx_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [ACC_W-1:0]   best_r, best_nxt;
  logic                      bestv_r, bestv_nxt;
  logic signed [COORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [PW-1:0]             rem_r, rem_nxt;
  logic [SW-1:0]             quo_r, quo_nxt;
  logic [DCW-1:0]            dcnt_r, dcnt_nxt;
  logic                      dneg_r, dneg_nxt;
  logic                      divy_r, divy_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                out_kind_r, out_kind_nxt;
  logic [3:0]                out_idx_r, out_idx_nxt;
  logic                      out_ovf_r, out_ovf_nxt;
  logic [6:0]                cw_r, lh_r;

  logic signed [DIFF_W-1:0]  mul_a, mul_b;
  logic                      in_acc;
  logic signed [DIFF_W-1:0]  px17, py17;
  logic [PW-1:0]             pairs;
  logic [UW+3:0]             idx_ext;
  logic [14:0]               limit;
  logic signed [ACC_W-1:0]   cr, dsq;
  logic [PW:0]               trial;
  logic                      qbit;
  logic [SW-1:0]             qfin, qres, ymag;
  logic signed [COORD_W-1:0] lox, hix, loy, hiy;
  logic                      on_edge, last_vtx, out_free;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign px17     = pt17(px_r);
  assign py17     = pt17(py_r);
  assign pairs    = rec_q.count[CW-1:1];
  assign limit    = ({8'd0, cw_r} * {8'd0, cw_r}) + ({8'd0, lh_r} * {8'd0, lh_r});
  assign cr       = acc_r - ext_prod(prod_r);
  assign dsq      = acc_r + ext_prod(prod_r);
  assign trial    = {rem_r, quo_r[SW-1]};
  assign qbit     = (trial >= {1'b0, pairs});
  assign qfin     = {quo_r[SW-2:0], qbit};
  assign qres     = dneg_r ? (~qfin + SW'(1)) : qfin;
  assign ymag     = rec_q.sumy[SW-1] ? SW'(-rec_q.sumy) : SW'(rec_q.sumy);
  assign lox      = (ax_r < bx_r) ? ax_r : bx_r;
  assign hix      = (ax_r < bx_r) ? bx_r : ax_r;
  assign loy      = (ay_r < by_r) ? ay_r : by_r;
  assign hiy      = (ay_r < by_r) ? by_r : ay_r;
  assign on_edge  = (cr == '0) && (px17 >= sx17(lox)) && (px17 <= sx17(hix)) &&
                    (py17 >= sx17(loy)) && (py17 <= sx17(hiy));
  assign last_vtx = ((k_r + CW'(1)) == {rec_q.count[CW-1:1], 1'b0});
  assign out_free = !out_valid_r || !out_stall;

  assign area_raddr  = (state_r == ST_IDLE) ? AW'(used_r - UW'(1)) : i_r[AW-1:0];
  assign coord_waddr = {AW'(used_r - UW'(1)), rec_q.count[KW-1:0]};

  // Area records and coordinates, registered reads
  always_ff @(posedge clk) begin
    if (area_we) begin
      area_mem[area_waddr] <= area_wdata;
    end
    rec_q <= area_mem[area_raddr];
  end

  always_ff @(posedge clk) begin
    if (coord_we) begin
      coord_mem[coord_waddr] <= cin_r;
    end
    cq <= coord_mem[{i_r[AW-1:0], k_r[KW-1:0]}];
  end

  // Shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Configuration registers
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {25'd0, lh_r} : {25'd0, cw_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= 7'd8;
      lh_r <= 7'd16;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        lh_r <= pwdata[6:0];
      end else begin
        cw_r <= pwdata[6:0];
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    used_nxt   = used_r;
    ovf_nxt    = ovf_r;
    open_nxt   = open_r;
    lastx_nxt  = lastx_r;
    cin_nxt    = cin_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    i_nxt      = i_r;
    k_nxt      = k_r;
    g_nxt      = g_r;
    ax_nxt     = ax_r;
    ay_nxt     = ay_r;
    bx_nxt     = bx_r;
    by_nxt     = by_r;
    fx_nxt     = fx_r;
    fy_nxt     = fy_r;
    closed_nxt = closed_r;
    wind_nxt   = wind_r;
    hdef_nxt   = hdef_r;
    didx_nxt   = didx_r;
    kind_nxt   = kind_r;
    idx_nxt    = idx_r;
    acc_nxt    = acc_r;
    best_nxt   = best_r;
    bestv_nxt  = bestv_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dcnt_nxt   = dcnt_r;
    dneg_nxt   = dneg_r;
    divy_nxt   = divy_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_ovf_nxt   = out_ovf_r;
    area_we    = 1'b0;
    area_waddr = AW'(used_r - UW'(1));
    area_wdata = rec_q;
    coord_we   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    idx_ext    = {4'd0, idx_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_action)
            ACT_CLEAR: begin
              used_nxt = '0;
              ovf_nxt  = 1'b0;
              open_nxt = 1'b0;
            end
            ACT_START: begin
              if (used_r == UW'(MAX_AREAS)) begin
                ovf_nxt  = 1'b1;
                open_nxt = 1'b0;
              end else begin
                area_we          = 1'b1;
                area_waddr       = used_r[AW-1:0];
                area_wdata.shape = (in_area_shape > SH_UNKNOWN) ? SH_UNKNOWN : in_area_shape;
                area_wdata.count = '0;
                area_wdata.sumx  = '0;
                area_wdata.sumy  = '0;
                used_nxt         = used_r + UW'(1);
                open_nxt         = 1'b1;
              end
            end
            ACT_APPEND: begin
              cin_nxt = in_coord_value;
              if (open_r) begin
                state_nxt = ST_APPEND;
              end
            end
            ACT_QUERY: begin
              px_nxt   = in_point_x;
              py_nxt   = in_point_y;
              i_nxt    = '0;
              hdef_nxt = 1'b0;
              kind_nxt = MK_NONE;
              idx_nxt  = '0;
              state_nxt = (used_r == '0) ? ST_DONE : ST_QRD;
            end
            default: ;
          endcase
        end
      end

      ST_APPEND: begin
        state_nxt = ST_IDLE;
        if (rec_q.shape == SH_RECT || rec_q.shape == SH_CIRCLE || rec_q.shape == SH_POLY) begin
          if (rec_q.count >= CW'(MAX_COORDS)) begin
            ovf_nxt = 1'b1;
          end else begin
            coord_we         = 1'b1;
            area_we          = 1'b1;
            area_wdata.count = rec_q.count + CW'(1);
            if (rec_q.shape == SH_CIRCLE) begin
              // A circle's centre is simply its first two coordinates.
              if (rec_q.count == CW'(0)) area_wdata.sumx = SW'(cin_r);
              if (rec_q.count == CW'(1)) area_wdata.sumy = SW'(cin_r);
            end else if (rec_q.count[0]) begin
              area_wdata.sumx = rec_q.sumx + SW'(lastx_r);
              area_wdata.sumy = rec_q.sumy + SW'(cin_r);
            end else begin
              lastx_nxt = cin_r;
            end
          end
        end
      end

      ST_QRD: state_nxt = ST_QREC;

      ST_QREC: begin
        k_nxt = '0;
        unique case (rec_q.shape)
          SH_DEFAULT: begin
            state_nxt = ST_NEXT;
            if (!hdef_r) begin
              hdef_nxt = 1'b1;
              didx_nxt = i_r;
              if (i_r == '0) begin
                kind_nxt  = MK_DEFAULT;
                idx_nxt   = '0;
                state_nxt = ST_DONE;
              end
            end
          end
          SH_RECT, SH_CIRCLE: state_nxt = ST_GA;
          SH_POLY: begin
            closed_nxt = 1'b0;
            wind_nxt   = '0;
            state_nxt  = (pairs == '0) ? ST_NEXT : ST_PXA;
          end
          default: state_nxt = ST_NEXT;
        endcase
      end

      ST_GA: state_nxt = ST_GB;

      ST_GB: begin
        g_nxt[k_r[1:0]] = (k_r < rec_q.count) ? sx17(cq) : '0;
        if (k_r == CW'(3)) begin
          state_nxt = ST_RECT;
        end else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = ST_GA;
        end
      end

      ST_RECT: begin
        if (rec_q.shape == SH_CIRCLE) begin
          state_nxt = ST_CDX;
        end else if (px17 >= g_r[0] && py17 >= g_r[1] && px17 <= g_r[2] && py17 <= g_r[3]) begin
          kind_nxt  = MK_INSIDE;
          idx_nxt   = i_r;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_NEXT;
        end
      end

      ST_CDX: begin
        mul_a     = px17 - g_r[0];
        mul_b     = mul_a;
        state_nxt = ST_CDY;
      end

      ST_CDY: begin
        acc_nxt   = ext_prod(prod_r);
        mul_a     = py17 - g_r[1];
        mul_b     = mul_a;
        state_nxt = ST_CR;
      end

      ST_CR: begin
        acc_nxt   = acc_r + ext_prod(prod_r);
        mul_a     = g_r[2];
        mul_b     = g_r[2];
        state_nxt = ST_CCMP;
      end

      ST_CCMP: begin
        if (acc_r <= ext_prod(prod_r)) begin
          kind_nxt  = MK_INSIDE;
          idx_nxt   = i_r;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_NEXT;
        end
      end

      ST_PXA: state_nxt = ST_PXB;

      ST_PXB: begin
        bx_nxt    = cq;
        k_nxt     = k_r + CW'(1);
        state_nxt = ST_PYA;
      end

      ST_PYA: state_nxt = ST_PYB;

      ST_PYB: begin
        by_nxt    = cq;
        state_nxt = ST_PVTX;
      end

      ST_PVTX: begin
        if (k_r == CW'(1)) begin
          // First vertex: remember it for the closing edge.
          fx_nxt = bx_r;
          fy_nxt = by_r;
          ax_nxt = bx_r;
          ay_nxt = by_r;
          if (last_vtx) begin
            closed_nxt = 1'b1;
            state_nxt  = ST_E1;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = ST_PXA;
          end
        end else begin
          state_nxt = ST_E1;
        end
      end

      ST_E1: begin
        mul_a     = sx17(bx_r) - sx17(ax_r);
        mul_b     = py17 - sx17(ay_r);
        state_nxt = ST_E2;
      end

      ST_E2: begin
        acc_nxt   = ext_prod(prod_r);
        mul_a     = px17 - sx17(ax_r);
        mul_b     = sx17(by_r) - sx17(ay_r);
        state_nxt = ST_E3;
      end

      ST_E3: begin
        if (on_edge) begin
          kind_nxt  = MK_INSIDE;
          idx_nxt   = i_r;
          state_nxt = ST_DONE;
        end else begin
          if (sx17(ay_r) <= py17) begin
            if (sx17(by_r) > py17 && cr > 0) wind_nxt = wind_r + (CW+1)'(1);
          end else begin
            if (sx17(by_r) <= py17 && cr < 0) wind_nxt = wind_r - (CW+1)'(1);
          end
          ax_nxt = bx_r;
          ay_nxt = by_r;
          if (closed_r) begin
            if (wind_nxt != '0) begin
              kind_nxt  = MK_INSIDE;
              idx_nxt   = i_r;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_NEXT;
            end
          end else if (last_vtx) begin
            bx_nxt     = fx_r;
            by_nxt     = fy_r;
            closed_nxt = 1'b1;
            state_nxt  = ST_E1;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = ST_PXA;
          end
        end
      end

      ST_NEXT: begin
        i_nxt = i_r + UW'(1);
        if ((i_r + UW'(1)) == used_r) begin
          if (hdef_r) begin
            kind_nxt  = MK_DEFAULT;
            idx_nxt   = didx_r;
            state_nxt = ST_DONE;
          end else begin
            i_nxt     = '0;
            bestv_nxt = 1'b0;
            state_nxt = ST_NRD;
          end
        end else begin
          state_nxt = ST_QRD;
        end
      end

      ST_NRD: state_nxt = ST_NREC;

      ST_NREC: begin
        cx_nxt = '0;
        cy_nxt = '0;
        state_nxt = ST_NDX;
        if (rec_q.shape == SH_CIRCLE) begin
          cx_nxt = rec_q.sumx[COORD_W-1:0];
          cy_nxt = rec_q.sumy[COORD_W-1:0];
        end else if ((rec_q.shape == SH_RECT || rec_q.shape == SH_POLY) && pairs != '0) begin
          quo_nxt   = rec_q.sumx[SW-1] ? SW'(-rec_q.sumx) : SW'(rec_q.sumx);
          dneg_nxt  = rec_q.sumx[SW-1];
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          divy_nxt  = 1'b0;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        // One restoring step per cycle on the magnitude of the pair sum.
        if (qbit) begin
          rem_nxt = PW'(trial - {1'b0, pairs});
        end else begin
          rem_nxt = trial[PW-1:0];
        end
        quo_nxt  = qfin;
        dcnt_nxt = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(SW - 1)) begin
          if (!divy_r) begin
            cx_nxt   = qres[COORD_W-1:0];
            quo_nxt  = ymag;
            dneg_nxt = rec_q.sumy[SW-1];
            rem_nxt  = '0;
            dcnt_nxt = '0;
            divy_nxt = 1'b1;
          end else begin
            cy_nxt    = qres[COORD_W-1:0];
            state_nxt = ST_NDX;
          end
        end
      end

      ST_NDX: begin
        mul_a     = sx17(cx_r) - px17;
        mul_b     = mul_a;
        state_nxt = ST_NDY;
      end

      ST_NDY: begin
        acc_nxt   = ext_prod(prod_r);
        mul_a     = sx17(cy_r) - py17;
        mul_b     = mul_a;
        state_nxt = ST_NCMP;
      end

      ST_NCMP: begin
        if ((!bestv_r || dsq < best_r) && dsq < $signed({{(ACC_W-15){1'b0}}, limit})) begin
          best_nxt  = dsq;
          bestv_nxt = 1'b1;
          idx_nxt   = i_r;
          kind_nxt  = MK_NEAREST;
        end
        i_nxt = i_r + UW'(1);
        state_nxt = ((i_r + UW'(1)) == used_r) ? ST_DONE : ST_NRD;
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_idx_nxt   = idx_ext[3:0];
          out_ovf_nxt   = ovf_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      ovf_r       <= ovf_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lastx_r  <= lastx_nxt;
    cin_r    <= cin_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    i_r      <= i_nxt;
    k_r      <= k_nxt;
    g_r      <= g_nxt;
    ax_r     <= ax_nxt;
    ay_r     <= ay_nxt;
    bx_r     <= bx_nxt;
    by_r     <= by_nxt;
    fx_r     <= fx_nxt;
    fy_r     <= fy_nxt;
    closed_r <= closed_nxt;
    wind_r   <= wind_nxt;
    hdef_r   <= hdef_nxt;
    didx_r   <= didx_nxt;
    kind_r   <= kind_nxt;
    idx_r    <= idx_nxt;
    acc_r    <= acc_nxt;
    best_r   <= best_nxt;
    bestv_r  <= bestv_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    dcnt_r   <= dcnt_nxt;
    dneg_r   <= dneg_nxt;
    divy_r   <= divy_nxt;
    out_kind_r <= out_kind_nxt;
    out_idx_r  <= out_idx_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_match_kind     = out_kind_r;
  assign out_area_index     = out_idx_r;
  assign out_table_overflow = out_ovf_r;

  `IMHT_ASSERT_NOW(a_used_bounded, 1'b1, used_r <= UW'(MAX_AREAS), "area count beyond table size")
  `IMHT_ASSERT_NOW(a_open_has_area, open_r, used_r != '0, "open area with empty table")
  `IMHT_ASSERT_NOW(a_none_index_zero, out_valid && out_match_kind == MK_NONE,
                   out_area_index == 4'd0, "no-area result with nonzero index")
  `IMHT_ASSERT_NEXT(a_done_delivers, state_r == ST_DONE && out_free,
                    out_valid && state_r == ST_IDLE, "finished query not presented")

endmodule

// File: tb/tb_image_map_hit_test.sv
// Self-checking testbench for the image-map hit test: table building, point queries, registers.
module tb_image_map_hit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import imht_pkg::*;

  localparam int AREA_CAP  = 16;
  localparam int COORD_CAP = 64;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] idx;
    logic       ovf;
  } hit_word_t;

  class hit_scoreboard;
    int unsigned char_w = 8, line_h = 16;
    int          areas_used;
    bit          overflow_seen, area_open;
    logic [2:0]  shape_of [AREA_CAP];
    int          count_of [AREA_CAP];
    longint      coords   [AREA_CAP][COORD_CAP];
    longint      ctr_x    [AREA_CAP];
    longint      ctr_y    [AREA_CAP];
    hit_word_t   awaited[$];
    int          errors;

    function longint coord_at(int a, int k);
      return (k < count_of[a]) ? coords[a][k] : 0;
    endfunction

    function void recentre(int a);
      longint sx, sy;
      int pairs;
      sx = 0;
      sy = 0;
      if (shape_of[a] == SH_CIRCLE) begin
        ctr_x[a] = coord_at(a, 0);
        ctr_y[a] = coord_at(a, 1);
        return;
      end
      ctr_x[a] = 0;
      ctr_y[a] = 0;
      if (shape_of[a] != SH_RECT && shape_of[a] != SH_POLY) return;
      pairs = count_of[a] / 2;
      if (pairs == 0) return;
      for (int k = 0; k < pairs; k++) begin
        sx += coord_at(a, 2 * k);
        sy += coord_at(a, 2 * k + 1);
      end
      ctr_x[a] = sx / pairs;
      ctr_y[a] = sy / pairs;
    endfunction

    // Nonzero winding count; points on a vertex or an edge are inside.
    function bit in_poly(int a, longint px, longint py);
      int n, j;
      longint wind, ax, ay, bx, by, cr;
      n = count_of[a] / 2;
      wind = 0;
      if (n == 0) return 0;
      for (int i = 0; i < n; i++) begin
        j = (i + 1 < n) ? i + 1 : 0;
        ax = coord_at(a, 2 * i);
        ay = coord_at(a, 2 * i + 1);
        bx = coord_at(a, 2 * j);
        by = coord_at(a, 2 * j + 1);
        cr = (bx - ax) * (py - ay) - (px - ax) * (by - ay);
        if (cr == 0 && px >= (ax < bx ? ax : bx) && px <= (ax < bx ? bx : ax) &&
            py >= (ay < by ? ay : by) && py <= (ay < by ? by : ay))
          return 1;
        if (ay <= py) begin
          if (by > py && cr > 0) wind++;
        end else if (by <= py && cr < 0) wind--;
      end
      return wind != 0;
    endfunction

    function bit contains(int a, longint px, longint py);
      longint dx, dy, r;
      case (shape_of[a])
        SH_RECT: return px >= coord_at(a, 0) && py >= coord_at(a, 1) &&
                        px <= coord_at(a, 2) && py <= coord_at(a, 3);
        SH_CIRCLE: begin
          dx = px - coord_at(a, 0);
          dy = py - coord_at(a, 1);
          r  = coord_at(a, 2);
          return dx * dx + dy * dy <= r * r;
        end
        SH_POLY: return in_poly(a, px, py);
        default: return 0;
      endcase
    endfunction

    function hit_word_t locate(longint px, longint py);
      hit_word_t w;
      bit have_def, done;
      int def_idx;
      longint lim, best, dx, dy, d;
      w = '{kind: MK_NONE, idx: 4'd0, ovf: overflow_seen};
      have_def = 0;
      done = 0;
      def_idx = 0;
      for (int i = 0; i < areas_used && !done; i++) begin
        if (shape_of[i] == SH_DEFAULT) begin
          if (!have_def) begin
            have_def = 1;
            def_idx = i;
            if (i == 0) done = 1;
          end
        end else if (contains(i, px, py)) begin
          w.kind = MK_INSIDE;
          w.idx = 4'(i);
          done = 1;
        end
      end
      if (w.kind != MK_INSIDE && have_def) begin
        w.kind = MK_DEFAULT;
        w.idx = 4'(def_idx);
      end else if (w.kind != MK_INSIDE && areas_used > 0) begin
        lim = longint'(char_w) * char_w + longint'(line_h) * line_h;
        best = -1;
        for (int i = 0; i < areas_used; i++) begin
          dx = ctr_x[i] - px;
          dy = ctr_y[i] - py;
          d = dx * dx + dy * dy;
          if ((best < 0 || d < best) && d < lim) begin
            best = d;
            w.idx = 4'(i);
            w.kind = MK_NEAREST;
          end
        end
      end
      return w;
    endfunction

    function void note_word(logic [1:0] act, logic [2:0] sh, logic signed [15:0] cv,
                            logic [14:0] px, logic [14:0] py);
      int a;
      case (act)
        ACT_CLEAR: begin
          areas_used = 0;
          overflow_seen = 0;
          area_open = 0;
        end
        ACT_START: begin
          if (areas_used >= AREA_CAP) begin
            overflow_seen = 1;
            area_open = 0;
          end else begin
            a = areas_used++;
            shape_of[a] = (sh > SH_UNKNOWN) ? SH_UNKNOWN : sh;
            count_of[a] = 0;
            area_open = 1;
            recentre(a);
          end
        end
        ACT_APPEND: begin
          if (area_open && areas_used > 0) begin
            a = areas_used - 1;
            if (shape_of[a] != SH_DEFAULT && shape_of[a] != SH_UNKNOWN) begin
              if (count_of[a] >= COORD_CAP) overflow_seen = 1;
              else begin
                coords[a][count_of[a]] = longint'(cv);
                count_of[a]++;
                recentre(a);
              end
            end
          end
        end
        default: awaited = {awaited, locate(longint'(px), longint'(py))};
      endcase
    endfunction

    function void check_word(logic [1:0] kind, logic [3:0] idx, logic ovf);
      hit_word_t e;
      if (awaited.size() == 0) begin
        $error("result word with nothing expected: kind %0d index %0d", kind, idx);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (kind !== e.kind) begin
        $error("match_kind: expected %0d, got %0d", e.kind, kind);
        errors++;
      end
      if (idx !== e.idx) begin
        $error("area_index: expected %0d, got %0d", e.idx, idx);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $error("table_overflow: expected %0d, got %0d", e.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall;
  logic [1:0] in_action = '0;
  logic [2:0] in_area_shape = '0;
  logic signed [15:0] in_coord_value = '0;
  logic [14:0] in_point_x = 15'd1, in_point_y = 15'd1;
  logic out_valid, out_stall = 1'b0;
  logic [1:0] out_match_kind;
  logic [3:0] out_area_index;
  logic out_table_overflow;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;

  image_map_hit_test u_dut (.*);

  hit_scoreboard sb = new();
  int tx_idle_pct, rx_idle_pct, hold_cycles, words_sent;
  longint cycle_no;

  initial forever #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no > 40_000_000) begin
      $display("tb_image_map_hit_test: errors");
      $finish;
    end
  end

  // Result side: check at the rising edge, choose the stall at the falling edge.
  initial begin
    cycle_no = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_word(out_match_kind, out_area_index, out_table_overflow);
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic send_word(logic [1:0] act, logic [2:0] sh, logic signed [15:0] cv,
                           logic [14:0] px, logic [14:0] py);
    if ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_action <= act;
    in_area_shape <= sh;
    in_coord_value <= cv;
    in_point_x <= px;
    in_point_y <= py;
    do @(posedge clk); while (in_stall);
    sb.note_word(act, sh, cv, px, py);
    words_sent++;
  endtask

  task automatic clear_table();
    send_word(ACT_CLEAR, 3'($urandom), 16'($urandom), 15'($urandom), 15'($urandom));
  endtask

  task automatic start_area(logic [2:0] sh);
    send_word(ACT_START, sh, 16'($urandom), 15'($urandom), 15'($urandom));
  endtask

  task automatic add_coord(logic signed [15:0] cv);
    send_word(ACT_APPEND, 3'($urandom), cv, 15'($urandom), 15'($urandom));
  endtask

  task automatic ask(logic [14:0] px, logic [14:0] py);
    send_word(ACT_QUERY, 3'($urandom), 16'($urandom), px, py);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == 3'd0) sb.char_w = val[6:0];
    else sb.line_h = val[6:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [14:0] near_pt(int base, int spread);
    int v;
    v = base + $urandom_range(2 * spread) - spread;
    return (v < 1) ? 15'd1 : (v > 32767) ? 15'd32767 : 15'(v);
  endfunction

  function automatic logic signed [15:0] near_coord(int base, int spread);
    if ($urandom_range(19) == 0) return 16'($urandom);
    return 16'(base + $urandom_range(2 * spread) - spread);
  endfunction

  // One table built from random areas, then a run of queries around it.
  task automatic random_scene();
    int base_x, base_y, n_areas, n_coords, spread;
    logic [2:0] sh;
    if ($urandom_range(3) != 0) clear_table();
    if ($urandom_range(9) == 0) add_coord(16'($urandom));
    base_x = ($urandom_range(7) == 0) ? $urandom_range(1, 32767) : $urandom_range(1, 600);
    base_y = ($urandom_range(7) == 0) ? $urandom_range(1, 32767) : $urandom_range(1, 600);
    spread = $urandom_range(10, 150);
    n_areas = ($urandom_range(11) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 5);
    for (int a = 0; a < n_areas; a++) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: sh = SH_RECT;
        6, 7, 8, 9:       sh = SH_CIRCLE;
        10, 11, 12, 13:   sh = SH_POLY;
        14, 15:           sh = SH_DEFAULT;
        16:               sh = SH_UNKNOWN;
        default:          sh = 3'($urandom_range(5, 7));
      endcase
      start_area(sh);
      case (sh)
        SH_RECT:   n_coords = ($urandom_range(4) == 0) ? $urandom_range(5) : 4;
        SH_CIRCLE: n_coords = ($urandom_range(4) == 0) ? $urandom_range(4) : 3;
        SH_POLY:   n_coords = ($urandom_range(15) == 0) ? $urandom_range(63, 66)
                                                         : $urandom_range(12);
        default:   n_coords = $urandom_range(2);
      endcase
      for (int k = 0; k < n_coords; k++) begin
        if (sh == SH_CIRCLE && k == 2) add_coord(16'($urandom_range(spread)));
        else add_coord(near_coord((k % 2) ? base_y : base_x, spread));
      end
    end
    repeat ($urandom_range(2, 8)) begin
      if ($urandom_range(9) == 0) ask(15'($urandom_range(1, 32767)), 15'($urandom_range(1, 32767)));
      else ask(near_pt(base_x, spread + 40), near_pt(base_y, spread + 40));
    end
  endtask

  initial begin
    tx_idle_pct = 14;
    rx_idle_pct = 61;
    hold_cycles = 0;
    words_sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening on the reset register values.
    ask(15'd1, 15'd1);
    start_area(SH_DEFAULT);
    start_area(SH_RECT);
    add_coord(16'sd10); add_coord(16'sd10); add_coord(16'sd100); add_coord(16'sd100);
    ask(15'd50, 15'd50);
    clear_table();
    start_area(SH_RECT);
    add_coord(16'sd10); add_coord(16'sd10); add_coord(16'sd100); add_coord(16'sd100);
    start_area(SH_CIRCLE);
    add_coord(16'sd300); add_coord(16'sd300); add_coord(16'sd20);
    start_area(SH_POLY);
    add_coord(16'sd500); add_coord(16'sd500); add_coord(16'sd600); add_coord(16'sd500);
    add_coord(16'sd550); add_coord(16'sd600); add_coord(16'sd7);
    start_area(3'd7);
    add_coord(16'sh7FFF);
    start_area(SH_CIRCLE);
    add_coord(-16'sd32768); add_coord(16'sh7FFF);
    ask(15'd600, 15'd500);
    ask(15'd320, 15'd300);
    ask(15'd105, 15'd104);
    ask(15'd32767, 15'd32767);
    drain();
    write_reg(3'd0, 32'd0);
    write_reg(3'd4, 32'd127);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 61 : 0;
      rx_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 14 : 0;
      for (int part = 0; part < 3; part++) begin
        if (phase == 0 && part == 1) hold_cycles = 600;
        while (words_sent < 160 * (3 * phase + part + 1) + 30) random_scene();
        // Nothing new is offered until every expected result is back.
        drain();
        case ($urandom_range(3))
          0: begin write_reg(3'd0, 32'd1);  write_reg(3'd4, 32'd64); end
          1: begin write_reg(3'd0, 32'd64); write_reg(3'd4, 32'd1);  end
          2: begin write_reg(3'd0, 32'd127); write_reg(3'd4, 32'd0); end
          default: begin
            write_reg(3'd0, $urandom);
            write_reg(3'd4, $urandom);
          end
        endcase
      end
    end
    while (words_sent < 1450) random_scene();

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) $display("tb_image_map_hit_test: clean");
    else $display("tb_image_map_hit_test: errors");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/imht_pkg.sv
hw/rtl/image_map_hit_test.sv
tb/tb_image_map_hit_test.sv
